@@ rtl/wpe_pkg.sv @@
package wpe_pkg;

  // Plane store geometry and sample format
  localparam int MaxHeight  = 64;
  localparam int MaxWidth   = 64;
  localparam int SampleBits = 16;
  localparam int MaxKernel  = 16;

  localparam int RowW   = $clog2(MaxHeight);
  localparam int ColW   = $clog2(MaxWidth);
  localparam int AddrW  = RowW + ColW;
  localparam int Depth  = MaxHeight * MaxWidth;

  // Field widths of the configuration registers
  localparam int DimW = 7;
  localparam int KerW = 5;
  localparam int PadW = 4;

  // Window arithmetic, accumulator and divider widths
  localparam int CalcW   = 14;
  localparam int ProdW   = RowW + KerW;
  localparam int SumW    = SampleBits + AddrW;
  localparam int CellW   = AddrW + 1;
  localparam int DivCntW = $clog2(SumW);

  localparam int ApbAddrW = 5;
  localparam int ApbDataW = 32;

  typedef enum logic [2:0] {
    REG_POOL_MODE    = 3'd0,
    REG_GLOBAL_POOL  = 3'd1,
    REG_WIN_SIDE     = 3'd2,
    REG_STRIDE       = 3'd3,
    REG_PAD          = 3'd4,
    REG_PLANE_HEIGHT = 3'd5,
    REG_PLANE_WIDTH  = 3'd6,
    REG_UNUSED       = 3'd7
  } reg_idx_e;

  typedef enum logic {
    KIND_LOAD    = 1'b0,
    KIND_REQUEST = 1'b1
  } kind_e;

  typedef struct packed {
    logic            pool_mode;
    logic            global_pool;
    logic [KerW-1:0] win_side;
    logic [KerW-1:0] stride;
    logic [PadW-1:0] pad;
    logic [DimW-1:0] plane_height;
    logic [DimW-1:0] plane_width;
  } cfg_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;
    logic start;
    logic calc;
    logic bound;
    logic clip;
    logic step;
    logic div_load;
    logic div_step;
    logic post;
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic valid;
    logic empty;
    logic last;
    logic div_last;
    logic avg;
  } sts_t;

endpackage

@@ rtl/window_pooling_engine_unit.sv @@
// Channel  | Direction | Handshake               | Word
// in       | input     | in_valid_i / in_stall_o | kind_i, row_i, col_i, sample_i
// out      | output    | out_valid_o/ out_stall_i| pooled_o, valid_res_o
// apb cfg  | input     | psel, penable, pready   | paddr, pwdata, prdata
//
// A load word returns nothing; loads may stream back to back.
// A request walks the clipped window; average pooling then divides the sum by cells, the
// window size with padding counted. The single read port of the plane store visits one
// cell a cycle and the divider retires one quotient bit a cycle over the 28-bit sum.
// An invalid or empty window skips the walk and goes straight to the output handover.
// The output register decouples out_stall_i: a new word is taken while a result waits.
// rst_ni resets control and the configuration; the plane store holds garbage until loaded.
module window_pooling_engine_unit (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic                                  kind_i,
  input  logic [5:0]                            row_i,
  input  logic [5:0]                            col_i,
  input  logic signed [15:0]                    sample_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic signed [15:0]                    pooled_o,
  output logic                                  valid_res_o,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [wpe_pkg::ApbAddrW-1:0]          paddr,
  input  logic [wpe_pkg::ApbDataW-1:0]          pwdata,
  output logic [wpe_pkg::ApbDataW-1:0]          prdata,
  output logic                                  pready
);
  import wpe_pkg::*;

  cfg_t     cfg_q;
  cmd_t     cmd;
  sts_t     sts;
  reg_idx_e reg_idx;
  logic     busy;
  logic     out_free;
  logic     out_valid_q;
  logic signed [SampleBits-1:0] pooled_q, result;
  logic     valid_res_q;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[ApbAddrW-1:2]);

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pool_mode    <= 1'b0;
      cfg_q.global_pool  <= 1'b0;
      cfg_q.win_side     <= KerW'(2);
      cfg_q.stride       <= KerW'(2);
      cfg_q.pad          <= '0;
      cfg_q.plane_height <= DimW'(64);
      cfg_q.plane_width  <= DimW'(64);
    end else if (psel && penable && pwrite && pready) begin
      case (reg_idx)
        REG_POOL_MODE:    cfg_q.pool_mode    <= pwdata[0];
        REG_GLOBAL_POOL:  cfg_q.global_pool  <= pwdata[0];
        REG_WIN_SIDE:     cfg_q.win_side     <= pwdata[KerW-1:0];
        REG_STRIDE:       cfg_q.stride       <= pwdata[KerW-1:0];
        REG_PAD:          cfg_q.pad          <= pwdata[PadW-1:0];
        REG_PLANE_HEIGHT: cfg_q.plane_height <= pwdata[DimW-1:0];
        REG_PLANE_WIDTH:  cfg_q.plane_width  <= pwdata[DimW-1:0];
        default: ;
      endcase
    end
  end

  // Register read-back
  always_comb begin
    case (reg_idx)
      REG_POOL_MODE:    prdata = ApbDataW'(cfg_q.pool_mode);
      REG_GLOBAL_POOL:  prdata = ApbDataW'(cfg_q.global_pool);
      REG_WIN_SIDE:     prdata = ApbDataW'(cfg_q.win_side);
      REG_STRIDE:       prdata = ApbDataW'(cfg_q.stride);
      REG_PAD:          prdata = ApbDataW'(cfg_q.pad);
      REG_PLANE_HEIGHT: prdata = ApbDataW'(cfg_q.plane_height);
      REG_PLANE_WIDTH:  prdata = ApbDataW'(cfg_q.plane_width);
      default:          prdata = '0;
    endcase
  end

  assign in_stall_o = busy;
  assign out_free   = !out_valid_q || !out_stall_i;

  wpe_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .kind_i     (kind_i),
    .out_free_i (out_free),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .busy_o     (busy)
  );

  wpe_dp u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .cmd_i    (cmd),
    .row_i    (row_i),
    .col_i    (col_i),
    .sample_i (sample_i),
    .sts_o    (sts),
    .result_o (result)
  );

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd.post) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd.post) begin
      pooled_q    <= result;
      valid_res_q <= sts.valid;
    end
  end

  assign out_valid_o = out_valid_q;
  assign pooled_o    = pooled_q;
  assign valid_res_o = valid_res_q;

endmodule

@@ rtl/wpe_ctrl.sv @@
module wpe_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          kind_i,
  input  logic          out_free_i,
  input  wpe_pkg::sts_t sts_i,
  output wpe_pkg::cmd_t cmd_o,
  output logic          busy_o
);
  import wpe_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CALC,
    ST_BOUND,
    ST_CLIP,
    ST_WALK,
    ST_DRAIN,
    ST_DSET,
    ST_DIV,
    ST_POST
  } state_e;

  state_e state_q;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i && kind_i == KIND_REQUEST) state_q <= ST_CALC;
        end
        ST_CALC:  state_q <= ST_BOUND;
        ST_BOUND: state_q <= ST_CLIP;
        ST_CLIP: begin
          if (sts_i.valid && !sts_i.empty) state_q <= ST_WALK;
          else                             state_q <= ST_POST;
        end
        ST_WALK: begin
          if (sts_i.last) state_q <= ST_DRAIN;
        end
        ST_DRAIN: begin
          if (sts_i.avg) state_q <= ST_DSET;
          else           state_q <= ST_POST;
        end
        ST_DSET: state_q <= ST_DIV;
        ST_DIV: begin
          if (sts_i.div_last) state_q <= ST_POST;
        end
        ST_POST: begin
          if (out_free_i) state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Command decode
  always_comb begin
    cmd_o          = '0;
    cmd_o.load     = (state_q == ST_IDLE) && in_valid_i && (kind_i == KIND_LOAD);
    cmd_o.start    = (state_q == ST_IDLE) && in_valid_i && (kind_i == KIND_REQUEST);
    cmd_o.calc     = (state_q == ST_CALC);
    cmd_o.bound    = (state_q == ST_BOUND);
    cmd_o.clip     = (state_q == ST_CLIP);
    cmd_o.step     = (state_q == ST_WALK);
    cmd_o.div_load = (state_q == ST_DSET);
    cmd_o.div_step = (state_q == ST_DIV);
    cmd_o.post     = (state_q == ST_POST) && out_free_i;
  end

  assign busy_o = (state_q != ST_IDLE);

endmodule

@@ rtl/wpe_dp.sv @@
module wpe_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  wpe_pkg::cfg_t                       cfg_i,
  input  wpe_pkg::cmd_t                       cmd_i,
  input  logic [wpe_pkg::RowW-1:0]            row_i,
  input  logic [wpe_pkg::ColW-1:0]            col_i,
  input  logic signed [wpe_pkg::SampleBits-1:0] sample_i,
  output wpe_pkg::sts_t                       sts_o,
  output logic signed [wpe_pkg::SampleBits-1:0] result_o
);
  import wpe_pkg::*;

  localparam logic signed [SampleBits-1:0] SampleMin = {1'b1, {(SampleBits-1){1'b0}}};

  logic [DimW-1:0] h_eff, w_eff, k_eff;
  logic [PadW-1:0] p_eff;
  logic [KerW-1:0] s_eff;
  logic [KerW-1:0] k_cfg;

  logic [RowW-1:0] row_q;
  logic [ColW-1:0] col_q;
  logic [ProdW-1:0] prod_r_q, prod_c_q;

  logic signed [CalcW-1:0] n_h, n_w, s_s, p_s, k_s, hlim, wlim;
  logic signed [CalcW-1:0] hs_raw, ws_raw, he_raw, we_raw;
  logic signed [CalcW-1:0] hs_q, he_q, ws_q, we_q;
  logic signed [CalcW-1:0] hs_c, he_c, ws_c, we_c, ext_h, ext_w;
  logic                    vld_d, vld_q, empty_c, empty_q;
  logic [CellW-1:0]        cells_q;

  logic [RowW-1:0] h_q, hend_q;
  logic [ColW-1:0] w_q, wstart_q, wend_q;
  logic            last_c;

  logic [SampleBits-1:0]        mem [Depth];
  logic signed [SampleBits-1:0] rd_q;
  logic                         rd_vld_q;

  logic signed [SampleBits-1:0] best_q;
  logic signed [SumW-1:0]       sum_q;

  logic [SumW-1:0]    quo_q;
  logic [CellW-1:0]   rem_q;
  logic [DivCntW-1:0] cnt_q;
  logic               neg_q;
  logic [CellW:0]     div_tmp;
  logic [SumW-1:0]    quo_signed;

  // Effective geometry after clamping and global mode
  always_comb begin
    h_eff = cfg_i.plane_height;
    if (cfg_i.plane_height == '0) h_eff = DimW'(1);
    else if (cfg_i.plane_height > DimW'(MaxHeight)) h_eff = DimW'(MaxHeight);
    w_eff = cfg_i.plane_width;
    if (cfg_i.plane_width == '0) w_eff = DimW'(1);
    else if (cfg_i.plane_width > DimW'(MaxWidth)) w_eff = DimW'(MaxWidth);
    k_cfg = cfg_i.win_side;
    if (cfg_i.win_side == '0) k_cfg = KerW'(1);
    else if (cfg_i.win_side > KerW'(MaxKernel)) k_cfg = KerW'(MaxKernel);
    if (cfg_i.global_pool) begin
      k_eff = h_eff;
      p_eff = '0;
      s_eff = KerW'(1);
    end else begin
      k_eff = DimW'(k_cfg);
      p_eff = cfg_i.pad;
      s_eff = (cfg_i.stride == '0) ? KerW'(1) : cfg_i.stride;
    end
  end

  // Ceil-mode validity of one axis: index 0 needs n >= 0 or -n < s,
  // otherwise (idx - 1) * s < n
  function automatic logic axis_ok(input logic zero_idx,
                                   input logic signed [CalcW-1:0] prod,
                                   input logic signed [CalcW-1:0] s,
                                   input logic signed [CalcW-1:0] n);
    logic ok;
    if (zero_idx) ok = (n >= 0) || (-n < s);
    else          ok = (prod - s) < n;
    return ok;
  endfunction

  // Window bounds before clipping
  always_comb begin
    s_s    = signed'(CalcW'(s_eff));
    p_s    = signed'(CalcW'(p_eff));
    k_s    = signed'(CalcW'(k_eff));
    n_h    = signed'(CalcW'(h_eff)) + p_s + p_s - k_s;
    n_w    = signed'(CalcW'(w_eff)) + p_s + p_s - k_s;
    hlim   = signed'(CalcW'(h_eff)) + p_s;
    wlim   = signed'(CalcW'(w_eff)) + p_s;
    hs_raw = signed'(CalcW'(prod_r_q)) - p_s;
    ws_raw = signed'(CalcW'(prod_c_q)) - p_s;
    he_raw = (hs_raw + k_s < hlim) ? hs_raw + k_s : hlim;
    we_raw = (ws_raw + k_s < wlim) ? ws_raw + k_s : wlim;
    vld_d  = axis_ok(row_q == '0, signed'(CalcW'(prod_r_q)), s_s, n_h) &&
             axis_ok(col_q == '0, signed'(CalcW'(prod_c_q)), s_s, n_w);
  end

  // Window clipped to the plane
  always_comb begin
    hs_c    = (hs_q < 0) ? '0 : hs_q;
    ws_c    = (ws_q < 0) ? '0 : ws_q;
    he_c    = (he_q > signed'(CalcW'(h_eff))) ? signed'(CalcW'(h_eff)) : he_q;
    we_c    = (we_q > signed'(CalcW'(w_eff))) ? signed'(CalcW'(w_eff)) : we_q;
    ext_h   = he_q - hs_q;
    ext_w   = we_q - ws_q;
    empty_c = !((hs_c < he_c) && (ws_c < we_c));
  end

  // Request set-up registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      row_q <= row_i;
      col_q <= col_i;
    end
    if (cmd_i.calc) begin
      prod_r_q <= ProdW'(row_q) * ProdW'(s_eff);
      prod_c_q <= ProdW'(col_q) * ProdW'(s_eff);
    end
    if (cmd_i.bound) begin
      hs_q <= hs_raw;
      he_q <= he_raw;
      ws_q <= ws_raw;
      we_q <= we_raw;
    end
    if (cmd_i.clip) begin
      cells_q  <= CellW'(ext_h[DimW-1:0]) * CellW'(ext_w[DimW-1:0]);
      h_q      <= hs_c[RowW-1:0];
      w_q      <= ws_c[ColW-1:0];
      wstart_q <= ws_c[ColW-1:0];
      hend_q   <= RowW'(he_c - 1);
      wend_q   <= ColW'(we_c - 1);
    end else if (cmd_i.step) begin
      if (w_q == wend_q) begin
        w_q <= wstart_q;
        h_q <= h_q + RowW'(1);
      end else begin
        w_q <= w_q + ColW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= 1'b0;
      empty_q  <= 1'b1;
      rd_vld_q <= 1'b0;
    end else begin
      if (cmd_i.start) vld_q <= 1'b0;
      else if (cmd_i.bound) vld_q <= vld_d;
      if (cmd_i.clip) empty_q <= empty_c;
      rd_vld_q <= cmd_i.step;
    end
  end

  assign last_c = (h_q == hend_q) && (w_q == wend_q);

  // Plane store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) mem[{row_i, col_i}] <= sample_i;
    rd_q <= signed'(mem[{h_q, w_q}]);
  end

  // Max and sum accumulators
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      best_q <= SampleMin;
      sum_q  <= '0;
    end else if (rd_vld_q) begin
      if (rd_q > best_q) best_q <= rd_q;
      sum_q <= sum_q + SumW'(rd_q);
    end
  end

  // Restoring divider, one quotient bit a cycle on the magnitude
  assign div_tmp = {rem_q, quo_q[SumW-1]};

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_load) begin
      neg_q <= sum_q[SumW-1];
      quo_q <= sum_q[SumW-1] ? SumW'(-sum_q) : SumW'(sum_q);
      rem_q <= '0;
      cnt_q <= DivCntW'(SumW - 1);
    end else if (cmd_i.div_step) begin
      if (div_tmp >= {1'b0, cells_q}) begin
        rem_q <= CellW'(div_tmp - {1'b0, cells_q});
        quo_q <= {quo_q[SumW-2:0], 1'b1};
      end else begin
        rem_q <= div_tmp[CellW-1:0];
        quo_q <= {quo_q[SumW-2:0], 1'b0};
      end
      cnt_q <= cnt_q - DivCntW'(1);
    end
  end

  assign quo_signed = neg_q ? SumW'(-quo_q) : quo_q;

  // Result selection
  always_comb begin
    if (!vld_q)                 result_o = '0;
    else if (!cfg_i.pool_mode)  result_o = best_q;
    else if (empty_q)           result_o = '0;
    else                        result_o = signed'(quo_signed[SampleBits-1:0]);
  end

  always_comb begin
    sts_o.valid    = vld_q;
    sts_o.empty    = empty_c;
    sts_o.last     = last_c;
    sts_o.div_last = (cnt_q == '0);
    sts_o.avg      = cfg_i.pool_mode;
  end

endmodule

@@ rtl/wpe_chk.sv @@
module wpe_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        kind_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [15:0] pooled_o,
  input logic        valid_res_o
);
  import wpe_pkg::*;

  // A stalled result word stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result word dropped while stalled");

  // A stalled result word holds its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(pooled_o) && $stable(valid_res_o))
    else $error("result word changed while stalled");

  // An out-of-range coordinate reports zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !valid_res_o |-> pooled_o == '0)
    else $error("invalid result carries a value");

  // A request word keeps the input stalled while it is worked on
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && kind_i == KIND_REQUEST |=> in_stall_o)
    else $error("input taken during a request");

  // A load word never stalls the input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && kind_i == KIND_LOAD |=> !in_stall_o)
    else $error("load stalled the input");

endmodule

bind window_pooling_engine_unit wpe_chk u_wpe_chk (.*);

@@ dv/wpe_checker.sv @@
`timescale 1ns / 100ps

module wpe_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_stall_o,
  input  logic                          kind_i,
  input  logic [5:0]                    row_i,
  input  logic [5:0]                    col_i,
  input  logic signed [15:0]            sample_i,
  input  logic                          out_valid_o,
  input  logic                          out_stall_i,
  input  logic signed [15:0]            pooled_o,
  input  logic                          valid_res_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic                          pready,
  input  logic [wpe_pkg::ApbAddrW-1:0]  paddr,
  input  logic [wpe_pkg::ApbDataW-1:0]  pwdata,
  output int                            pending_o,
  output int                            errors_o
);
  import wpe_pkg::*;

  typedef struct {
    logic signed [15:0] pooled;
    logic               valid_res;
  } pool_word_t;

  // Shadow of the plane store and the register set
  logic signed [15:0] plane_mem [0:Depth-1];
  cfg_t               cfg_q;
  pool_word_t         pool_expected_q [$];
  int                 errors;

  initial begin
    cfg_q.pool_mode    = 1'b0;
    cfg_q.global_pool  = 1'b0;
    cfg_q.win_side     = 5'd2;
    cfg_q.stride       = 5'd2;
    cfg_q.pad          = 4'd0;
    cfg_q.plane_height = 7'd64;
    cfg_q.plane_width  = 7'd64;
    errors             = 0;
  end

  assign pending_o = pool_expected_q.size();
  assign errors_o  = errors;

  function automatic int clamp_dim(int v, int hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  // Ceil-mode output extent, may be zero or negative
  function automatic int out_extent(int n, int s);
    if (n >= 0) return (n + s - 1) / s + 1;
    return 1 - ((-n) / s);
  endfunction

  // Expected pooled word for one request
  function automatic pool_word_t pool_window(int r, int c);
    pool_word_t res;
    int h_dim, w_dim, ker, pd, st, oh, ow;
    int hs, ws, he, we, cells, best, sum;
    bit any;
    h_dim = clamp_dim(cfg_q.plane_height, MaxHeight);
    w_dim = clamp_dim(cfg_q.plane_width, MaxWidth);
    if (cfg_q.global_pool) begin
      ker = h_dim; pd = 0; st = 1;
    end else begin
      ker = clamp_dim(cfg_q.win_side, MaxKernel);
      pd  = cfg_q.pad;
      st  = (cfg_q.stride == 0) ? 1 : cfg_q.stride;
    end
    oh = out_extent(h_dim + 2 * pd - ker, st);
    ow = out_extent(w_dim + 2 * pd - ker, st);
    res.valid_res = (r < oh) && (c < ow);
    res.pooled    = '0;
    if (res.valid_res) begin
      hs = r * st - pd;
      ws = c * st - pd;
      he = (hs + ker < h_dim + pd) ? hs + ker : h_dim + pd;
      we = (ws + ker < w_dim + pd) ? ws + ker : w_dim + pd;
      cells = (he - hs) * (we - ws);
      if (hs < 0) hs = 0;
      if (ws < 0) ws = 0;
      if (he > h_dim) he = h_dim;
      if (we > w_dim) we = w_dim;
      best = -32768;
      sum  = 0;
      any  = 1'b0;
      for (int h = hs; h < he; h++)
        for (int w = ws; w < we; w++) begin
          if (plane_mem[h * MaxWidth + w] > best) best = plane_mem[h * MaxWidth + w];
          sum += plane_mem[h * MaxWidth + w];
          any = 1'b1;
        end
      if (!cfg_q.pool_mode) res.pooled = best[15:0];
      else if (any && cells > 0) res.pooled = 16'(sum / cells);
    end
    return res;
  endfunction

  // Register writes on the configuration port
  always @(posedge clk_i) begin
    if (rst_ni && psel && penable && pwrite && pready) begin
      case (reg_idx_e'(paddr[4:2]))
        REG_POOL_MODE:    cfg_q.pool_mode    <= pwdata[0];
        REG_GLOBAL_POOL:  cfg_q.global_pool  <= pwdata[0];
        REG_WIN_SIDE:     cfg_q.win_side     <= pwdata[KerW-1:0];
        REG_STRIDE:       cfg_q.stride       <= pwdata[KerW-1:0];
        REG_PAD:          cfg_q.pad          <= pwdata[PadW-1:0];
        REG_PLANE_HEIGHT: cfg_q.plane_height <= pwdata[DimW-1:0];
        REG_PLANE_WIDTH:  cfg_q.plane_width  <= pwdata[DimW-1:0];
        default: ;
      endcase
    end
  end

  // Input words: loads update the shadow, requests queue a prediction
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) begin
      if (kind_e'(kind_i) == KIND_LOAD) plane_mem[{row_i, col_i}] = sample_i;
      else pool_expected_q.push_back(pool_window(row_i, col_i));
    end
  end

  // Output words against the oldest prediction
  always @(posedge clk_i) begin
    pool_word_t exp_w;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pool_expected_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result word: pooled=%0d valid_res=%0b",
                                   pooled_o, valid_res_o);
      end else begin
        exp_w = pool_expected_q.pop_front();
        if (exp_w.pooled !== pooled_o || exp_w.valid_res !== valid_res_o) begin
          errors++;
          if (errors <= 10)
            $display("result mismatch: pooled exp %0d got %0d, valid_res exp %0b got %0b",
                     exp_w.pooled, pooled_o, exp_w.valid_res, valid_res_o);
        end
      end
    end
  end

endmodule

@@ dv/tb_window_pooling_engine_unit.sv @@
`timescale 1ns / 100ps

module tb_window_pooling_engine_unit;
  import wpe_pkg::*;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  logic                 kind_i = 1'b0;
  logic [5:0]           row_i = '0;
  logic [5:0]           col_i = '0;
  logic signed [15:0]   sample_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic signed [15:0]   pooled_o;
  logic                 valid_res_o;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [ApbAddrW-1:0]  paddr = '0;
  logic [ApbDataW-1:0]  pwdata = '0;
  logic [ApbDataW-1:0]  prdata;
  logic                 pready;
  int                   pending, errors;
  bit                   quiet = 1'b0;
  int                   n_loads = 0, n_reqs = 0, n_settings = 0;

  always #5 clk_i = ~clk_i;

  window_pooling_engine_unit DUT (.*);

  wpe_checker u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .kind_i, .row_i, .col_i, .sample_i,
    .out_valid_o, .out_stall_i, .pooled_o, .valid_res_o,
    .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
    .pending_o(pending), .errors_o(errors)
  );

  // Receiver stalls in random bursts, except in the quiet phase
  always @(posedge clk_i) begin
    int burst;
    if (burst > 0) begin
      burst--;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      burst = $urandom_range(1, 3);
    end
    out_stall_i <= (!quiet && burst > 0) ? 1'b1 : 1'b0;
    if (quiet) burst = 0;
  end

  task automatic send_word(kind_e k, logic [5:0] r, logic [5:0] c, logic [15:0] s);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i     <= k;
    row_i      <= r;
    col_i      <= c;
    sample_i   <= s;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (k == KIND_LOAD) n_loads++;
    else n_reqs++;
  endtask

  // Drain all results, then let a window walk and divide finish
  task automatic settle();
    in_valid_i <= 1'b0;
    repeat (2) @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (320) @(posedge clk_i);
  endtask

  task automatic reg_write(reg_idx_e idx, logic [31:0] v);
    @(posedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  task automatic set_all(int m, int g, int k, int st, int p, int h, int w);
    reg_write(REG_POOL_MODE, m);
    reg_write(REG_GLOBAL_POOL, g);
    reg_write(REG_WIN_SIDE, k);
    reg_write(REG_STRIDE, st);
    reg_write(REG_PAD, p);
    reg_write(REG_PLANE_HEIGHT, h);
    reg_write(REG_PLANE_WIDTH, w);
    n_settings++;
  endtask

  task automatic request(int r, int c);
    send_word(KIND_REQUEST, r[5:0], c[5:0], 16'($urandom));
  endtask

  // Random setting; planes stay within the preloaded 16 x 16 corner
  task automatic random_setting();
    int h, w;
    h = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 16) : $urandom_range(1, 12);
    w = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 16) : $urandom_range(1, 12);
    if ($urandom_range(0, 4) == 0) begin
      h = $urandom_range(1, 8);
      set_all($urandom_range(0, 1), 1, $urandom_range(0, 31), $urandom_range(0, 31),
              $urandom_range(0, 15), h, w);
    end else begin
      set_all($urandom_range(0, 1), 0,
              ($urandom_range(0, 7) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 5),
              ($urandom_range(0, 7) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 3),
              ($urandom_range(0, 7) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 2),
              h, w);
    end
    if ($urandom_range(0, 3) == 0) reg_write(REG_UNUSED, $urandom);
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Preload a 16 x 16 corner plus the whole first row and column;
    // every window below reads only these cells
    for (int a = 0; a < 256; a++)
      send_word(KIND_LOAD, {2'b00, a[7:4]}, {2'b00, a[3:0]}, 16'($urandom));
    for (int i = 16; i < 64; i++) begin
      send_word(KIND_LOAD, 6'd0, 6'(i), 16'($urandom));
      send_word(KIND_LOAD, 6'(i), 6'd0, 16'($urandom));
    end

    // Directed: extremes under the reset setting
    send_word(KIND_LOAD, 6'd0, 6'd0, 16'sh7fff);
    send_word(KIND_LOAD, 6'd0, 6'd1, 16'sh8000);
    send_word(KIND_LOAD, 6'd15, 6'd15, 16'sh8000);
    request(0, 0);
    request(7, 7);
    request(32, 0);
    request(63, 63);
    settle();
    // average with padding cells counted
    set_all(1, 0, 3, 2, 1, 16, 16);
    request(0, 0);
    request(8, 8);
    request(9, 0);
    settle();
    // windows that clip to nothing
    set_all(0, 0, 1, 16, 15, 64, 64);
    request(0, 0);
    request(6, 6);
    settle();
    reg_write(REG_POOL_MODE, 1);
    request(0, 6);
    settle();
    // out-of-range kernel, stride and plane sizes
    set_all(0, 0, 0, 0, 0, 0, 127);
    request(0, 0);
    request(0, 63);
    settle();
    reg_write(REG_WIN_SIDE, 31);
    reg_write(REG_PLANE_HEIGHT, 127);
    request(0, 0);
    request(49, 0);
    request(0, 49);
    settle();
    // global mode, small plane
    set_all(1, 1, 9, 9, 9, 4, 6);
    request(0, 0);
    request(0, 2);
    request(1, 0);
    settle();

    // Random phases; the last one runs without idling
    for (int ph = 0; ph < 10; ph++) begin
      if (ph == 9) quiet = 1'b1;
      random_setting();
      for (int i = 0; i < 100; i++) begin
        if ($urandom_range(0, 2) == 0)
          send_word(KIND_LOAD, 6'($urandom_range(0, 15)), 6'($urandom_range(0, 15)),
                    16'($urandom));
        else if ($urandom_range(0, 4) == 0)
          request($urandom_range(0, 63), $urandom_range(0, 63));
        else
          request($urandom_range(0, 7), $urandom_range(0, 7));
      end
      settle();
    end

    $display("covered %0d loads and %0d pooling requests over %0d register settings",
             n_loads, n_reqs, n_settings);
    if (errors == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #40ms;
    $display("timeout");
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/wpe_pkg.sv
rtl/wpe_ctrl.sv
rtl/wpe_dp.sv
rtl/window_pooling_engine_unit.sv
rtl/wpe_chk.sv
dv/wpe_checker.sv
dv/tb_window_pooling_engine_unit.sv
